// ===== rtl/tmalu_pkg.sv =====
// ----------------------------------------------------------------------------
// tmalu_pkg
// Types and codes shared by the toy machine ALU.
// ----------------------------------------------------------------------------
package tmalu_pkg;

  typedef enum logic [2:0] {
    KIND_INT_ADD   = 3'd0,
    KIND_FLOAT_ADD = 3'd1,
    KIND_OR        = 3'd2,
    KIND_AND       = 3'd3,
    KIND_XOR       = 3'd4,
    KIND_ROR       = 3'd5
  } kind_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] operand_a;
    logic [7:0] operand_b;
    logic [3:0] rotate_amount;
  } alu_in_t;

  typedef struct packed {
    logic [7:0] result;
    logic       overflow;
  } alu_out_t;

  // stage 1 -> stage 2: signed float sum and early results
  typedef struct packed {
    logic       valid;
    logic       is_float;
    logic [7:0] early_result;
    logic       early_ovf;
    logic [12:0] sum;   // signed float sum, units of 2^-8
  } s1_t;

  // stage 2 -> stage 3: sign and magnitude
  typedef struct packed {
    logic       valid;
    logic       is_float;
    logic [7:0] early_result;
    logic       early_ovf;
    logic       sign;
    logic [11:0] mag;
  } s2_t;

endpackage

// ===== rtl/tmalu_front.sv =====
// ----------------------------------------------------------------------------
// tmalu_front
// Stage 1: integer and logic ops, float operand alignment and signed add.
// ----------------------------------------------------------------------------
module tmalu_front import tmalu_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  alu_in_t in_beat,
  output s1_t     s1
);

  logic [8:0]  int_sum;
  logic [12:0] va, vb;
  logic [7:0]  res;
  logic        ovf;
  logic [2:0]  amt;

  always_comb begin
    int_sum = {1'b0, in_beat.operand_a} + {1'b0, in_beat.operand_b};
    amt = in_beat.rotate_amount[2:0];
    va = 13'(in_beat.operand_a[3:0]) << in_beat.operand_a[6:4];
    vb = 13'(in_beat.operand_b[3:0]) << in_beat.operand_b[6:4];
    if (in_beat.operand_a[7]) va = -va;
    if (in_beat.operand_b[7]) vb = -vb;
    res = '0;
    ovf = 1'b0;
    case (in_beat.kind)
      KIND_INT_ADD: begin
        res = int_sum[7:0];
        ovf = (in_beat.operand_a[7] == in_beat.operand_b[7]) &&
              (int_sum[7] != in_beat.operand_a[7]);
      end
      KIND_OR:  res = in_beat.operand_a | in_beat.operand_b;
      KIND_AND: res = in_beat.operand_a & in_beat.operand_b;
      KIND_XOR: res = in_beat.operand_a ^ in_beat.operand_b;
      KIND_ROR: res = 8'({in_beat.operand_a, in_beat.operand_a} >> amt);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else begin
      s1.valid <= in_valid;
    end
    s1.is_float     <= (in_beat.kind == KIND_FLOAT_ADD);
    s1.early_result <= res;
    s1.early_ovf    <= ovf;
    s1.sum          <= va + vb;
  end

endmodule

// ===== rtl/tmalu_mag.sv =====
// ----------------------------------------------------------------------------
// tmalu_mag
// Stage 2: sign and magnitude of the float sum.
// ----------------------------------------------------------------------------
module tmalu_mag import tmalu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  s1_t  s1,
  output s2_t  s2
);

  logic [12:0] neg;

  assign neg = -s1.sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
    end else begin
      s2.valid <= s1.valid;
    end
    s2.is_float     <= s1.is_float;
    s2.early_result <= s1.early_result;
    s2.early_ovf    <= s1.early_ovf;
    s2.sign         <= s1.sum[12];
    s2.mag          <= s1.sum[12] ? neg[11:0] : s1.sum[11:0];
  end

endmodule

// ===== rtl/tmalu_norm.sv =====
// ----------------------------------------------------------------------------
// tmalu_norm
// Stage 3: normalize, truncate, saturate and select the result.
// ----------------------------------------------------------------------------
module tmalu_norm import tmalu_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  s2_t      s2,
  output logic     done,
  output alu_out_t out_beat
);

  logic [3:0] e;
  logic [3:0] m;
  logic [7:0] fres;
  logic       fovf;

  always_comb begin
    e = 4'd0;
    for (int i = 4; i < 12; i++) begin
      if (s2.mag[i]) e = 4'(i - 3);
    end
    m = 4'(s2.mag >> e);
    fovf = (e > 4'd7);
    if (s2.mag == '0)  fres = 8'h00;
    else if (fovf)     fres = {s2.sign, 7'h7f};
    else               fres = {s2.sign, e[2:0], m};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s2.valid;
    end
    out_beat.result   <= s2.is_float ? fres : s2.early_result;
    out_beat.overflow <= s2.is_float ? fovf : s2.early_ovf;
  end

endmodule

// ===== rtl/toy_machine_alu_8bit.sv =====
// ----------------------------------------------------------------------------
// toy_machine_alu_8bit
// 8-bit ALU of a textbook machine: int add, float add, or, and, xor, rotate.
// ----------------------------------------------------------------------------
// An operation is taken whenever start is high; busy is always low, so one
// beat enters per cycle. Each result appears for one cycle with done high,
// after passing through the three register stages (align and add,
// sign/magnitude, normalize). The receiver cannot stall.
module toy_machine_alu_8bit import tmalu_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  alu_in_t  operation,
  output logic     done,
  output alu_out_t answer
);

  s1_t s1;
  s2_t s2;

  assign busy = 1'b0;

  tmalu_front u_front (.clk, .rst, .in_valid(start), .in_beat(operation), .s1);
  tmalu_mag   u_mag   (.clk, .rst, .s1, .s2);
  tmalu_norm  u_norm  (.clk, .rst, .s2, .done, .out_beat(answer));

endmodule
